// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL. All of them are clocked on
// clk and switched off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check with a message
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: antecedent in this cycle, consequent in the next
`define AST_NEXT(lbl, ante, cons, msg) \
  `AST_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/nvht_pkg.sv -----
// ---------------------------------------------------------------------------
// nvht_pkg
// Types and constants for the nearest vertex hit test block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nvht_pkg;

  // Field widths fixed by the interface
  localparam int COORD_W   = 16;
  localparam int RANGE_W   = 8;
  localparam int COUNT_W   = 7;
  localparam int OUT_IDX_W = 6;
  localparam int IN_IDX_W  = 6;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * RANGE_W;
  localparam int DIST_W    = SQ_W + 1;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Register word addresses (paddr[2])
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_REACH        = 1'b1;

  // Register reset values
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd0;
  localparam logic [RANGE_W-1:0] REACH_RESET        = 8'd8;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage : nvht_pkg

`default_nettype wire

// ----- rtl/core/nearest_vertex_hit_test.sv -----
// Query: the scan reads one memory entry per cycle, walked from N-1 down to 0,
// then the pipeline drains and the result strobe follows (earlier when the
// last entries miss the window; straight to the drain when N is 0);
// N = vertex_count saturated to MAX_VERTICES. Busy until the cycle before the
// strobe. Vertex writes never raise busy.
// Reset (rst_n, sync): control, vertex_count 0, window 8; memory kept.
// ---------------------------------------------------------------------------
// nearest_vertex_hit_test
// Keeps a table of polygon vertices and, on a query, returns the nearest
// vertex inside a square grab window around the pointer (highest index wins
// ties). Memory read, window test, squaring and best update are pipelined.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nearest_vertex_hit_test #(
  parameter int MAX_VERTICES = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // command channel
  input  wire                               start,
  output logic                              busy,
  input  wire                               in_command,
  input  wire  [nvht_pkg::IN_IDX_W-1:0]     in_vertex_index,
  input  wire  signed [nvht_pkg::COORD_W-1:0] in_pos_x,
  input  wire  signed [nvht_pkg::COORD_W-1:0] in_pos_y,
  // result channel
  output logic                              out_strobe,
  output logic                              out_found,
  output logic [nvht_pkg::OUT_IDX_W-1:0]    out_match_index,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [nvht_pkg::PADDR_W-1:0]      paddr,
  input  wire  [nvht_pkg::PDATA_W-1:0]      pwdata,
  output logic [nvht_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CW    = ($clog2(MAX_VERTICES + 1) > nvht_pkg::COUNT_W) ?
                         $clog2(MAX_VERTICES + 1) : nvht_pkg::COUNT_W;
  localparam int MEM_W = 2 * nvht_pkg::COORD_W;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [nvht_pkg::COUNT_W-1:0] vertex_count_r;
  logic [nvht_pkg::RANGE_W-1:0] reach_r;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= nvht_pkg::VERTEX_COUNT_RESET;
      reach_r        <= nvht_pkg::REACH_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        nvht_pkg::REG_VERTEX_COUNT: vertex_count_r <= pwdata[nvht_pkg::COUNT_W-1:0];
        nvht_pkg::REG_REACH:        reach_r        <= pwdata[nvht_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (paddr[2])
      nvht_pkg::REG_VERTEX_COUNT: prdata = nvht_pkg::PDATA_W'(vertex_count_r);
      nvht_pkg::REG_REACH:        prdata = nvht_pkg::PDATA_W'(reach_r);
      default:                    prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Transaction accept and search bounds
  // -------------------------------------------------------------------------
  nvht_pkg::state_t state_r, state_nxt;
  logic             accept;
  logic             mem_we;
  logic             wr_idx_ok;
  logic [CW-1:0]    cnt_ext;
  logic [CW-1:0]    cnt_sat;

  assign busy      = (state_r != nvht_pkg::ST_IDLE);
  assign accept    = start & ~busy;
  assign wr_idx_ok = (32'(in_vertex_index) < MAX_VERTICES);
  assign mem_we    = accept & (in_command == nvht_pkg::CMD_WRITE) & wr_idx_ok;

  assign cnt_ext = CW'(vertex_count_r);
  assign cnt_sat = (cnt_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cnt_ext;

  // pointer position held for the whole scan
  logic signed [nvht_pkg::COORD_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             issue;
  logic             rd_vld_r, a_vld_r, b_vld_r;
  logic             pipe_empty;
  logic             done;
  logic             query_go;

  assign pipe_empty = ~rd_vld_r & ~a_vld_r & ~b_vld_r;
  assign query_go   = accept & (in_command == nvht_pkg::CMD_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nvht_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    addr_r <= addr_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    issue     = 1'b0;
    done      = 1'b0;
    case (state_r)
      nvht_pkg::ST_IDLE: begin
        if (query_go) begin
          addr_nxt = IDX_W'(cnt_sat - CW'(1));
          if (cnt_sat == '0) begin
            state_nxt = nvht_pkg::ST_DRAIN;
          end else begin
            state_nxt = nvht_pkg::ST_SCAN;
          end
        end
      end
      nvht_pkg::ST_SCAN: begin
        issue = 1'b1;
        if (addr_r == '0) begin
          state_nxt = nvht_pkg::ST_DRAIN;
        end else begin
          addr_nxt = addr_r - IDX_W'(1);
        end
      end
      nvht_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          done      = 1'b1;
          state_nxt = nvht_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nvht_pkg::ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Vertex memory: {x, y} per entry, one write and one registered read
  // -------------------------------------------------------------------------
  logic [MEM_W-1:0] vtx_mem [MAX_VERTICES];
  logic [MEM_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vtx_mem[IDX_W'(in_vertex_index)] <= {in_pos_x, in_pos_y};
    end
    if (issue) begin
      rd_data_r <= vtx_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
    end
    if (issue) begin
      rd_idx_r <= addr_r;
    end
  end

  // -------------------------------------------------------------------------
  // Stage A: per-axis distance and grab window test
  // -------------------------------------------------------------------------
  logic signed [nvht_pkg::DIFF_W-1:0] diff_x, diff_y;
  logic        [nvht_pkg::DIFF_W-1:0] mag_x, mag_y;
  logic        [nvht_pkg::DIFF_W-1:0] range_ext;
  logic                               in_window;
  logic        [nvht_pkg::RANGE_W-1:0] dx_r, dy_r;
  logic        [IDX_W-1:0]            a_idx_r;

  assign diff_x = {px_r[nvht_pkg::COORD_W-1], px_r}
                - {rd_data_r[MEM_W-1], rd_data_r[MEM_W-1:nvht_pkg::COORD_W]};
  assign diff_y = {py_r[nvht_pkg::COORD_W-1], py_r}
                - {rd_data_r[nvht_pkg::COORD_W-1], rd_data_r[nvht_pkg::COORD_W-1:0]};
  assign mag_x  = diff_x[nvht_pkg::DIFF_W-1] ? nvht_pkg::DIFF_W'(-diff_x)
                                             : nvht_pkg::DIFF_W'(diff_x);
  assign mag_y  = diff_y[nvht_pkg::DIFF_W-1] ? nvht_pkg::DIFF_W'(-diff_y)
                                             : nvht_pkg::DIFF_W'(diff_y);
  assign range_ext = nvht_pkg::DIFF_W'(reach_r);
  assign in_window = (mag_x < range_ext) & (mag_y < range_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= rd_vld_r & in_window;
    end
    dx_r    <= mag_x[nvht_pkg::RANGE_W-1:0];
    dy_r    <= mag_y[nvht_pkg::RANGE_W-1:0];
    a_idx_r <= rd_idx_r;
  end

  // -------------------------------------------------------------------------
  // Stage B: squares
  // -------------------------------------------------------------------------
  logic [nvht_pkg::SQ_W-1:0] sqx_r, sqy_r;
  logic [IDX_W-1:0]          b_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    sqx_r   <= dx_r * dx_r;
    sqy_r   <= dy_r * dy_r;
    b_idx_r <= a_idx_r;
  end

  // -------------------------------------------------------------------------
  // Stage C: best-so-far; a lower index replaces only when strictly closer
  // -------------------------------------------------------------------------
  logic [nvht_pkg::DIST_W-1:0] sum_sq;
  logic [nvht_pkg::DIST_W-1:0] best_d_r;
  logic [IDX_W-1:0]            best_idx_r;
  logic                        have_r;

  assign sum_sq = nvht_pkg::DIST_W'(sqx_r) + nvht_pkg::DIST_W'(sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (query_go) begin
      have_r <= 1'b0;
    end else if (b_vld_r && (!have_r || best_d_r > sum_sq)) begin
      have_r <= 1'b1;
    end
    if (b_vld_r && (!have_r || best_d_r > sum_sq)) begin
      best_d_r   <= sum_sq;
      best_idx_r <= b_idx_r;
    end
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  logic                          out_strobe_r;
  logic                          out_found_r;
  logic [nvht_pkg::OUT_IDX_W-1:0] out_match_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= done;
    end
    if (done) begin
      out_found_r       <= have_r;
      out_match_index_r <= have_r ? nvht_pkg::OUT_IDX_W'(best_idx_r) : '0;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_match_index_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `AST_CLK(a_strb_drain, out_strobe_r |-> $past(state_r == nvht_pkg::ST_DRAIN), "stray strobe")
  `AST_CLK(a_miss_zero, (out_strobe_r && !out_found_r) |-> (out_match_index_r == '0), "miss idx")
  `AST_CLK(a_read_scan, rd_vld_r |-> $past(state_r == nvht_pkg::ST_SCAN), "read outside scan")
  `AST_NEXT(a_drain_idle, state_r == nvht_pkg::ST_DRAIN, !rd_vld_r, "read while draining")

endmodule : nearest_vertex_hit_test

`default_nettype wire
